// ===== src/assert_macros.svh =====
// assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion with asynchronous active-low reset disable
`define LG_ASSERT_ON(lbl, ck, rst_n, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (prop)) else $error(msg);

// clocked assertion on the usual clk / arst_n pair
`define LG_ASSERT(lbl, prop, msg) \
	`LG_ASSERT_ON(lbl, clk, arst_n, prop, msg)

`endif

// ===== src/lifeg_pkg.sv =====
// constants, codes and helpers shared by the life grid files
`default_nettype none

package lifeg_pkg;

	localparam int GRID_SIZE  = 64;
	localparam int ROW_W      = GRID_SIZE;
	localparam int ROW_AW     = $clog2(GRID_SIZE);
	localparam int COORD_SPAN = 64;
	localparam int EXT_W      = 7;

	localparam logic [EXT_W-1:0] EXT_RESET = 7'd50;

	// configuration register indexes
	localparam logic REG_ACTIVE_WIDTH  = 1'b0;
	localparam logic REG_ACTIVE_HEIGHT = 1'b1;

	// operation codes
	localparam logic [1:0] OP_SET     = 2'd0;
	localparam logic [1:0] OP_CLEAR   = 2'd1;
	localparam logic [1:0] OP_READ    = 2'd2;
	localparam logic [1:0] OP_ADVANCE = 2'd3;

	// clamp a register value to the usable extent of the grid
	function automatic logic [EXT_W-1:0] eff_extent(input logic [EXT_W-1:0] v);
		logic [EXT_W-1:0] r;
		r = v;
		if (r > EXT_W'(COORD_SPAN))
			r = EXT_W'(COORD_SPAN);
		if ((GRID_SIZE < COORD_SPAN) && (r > EXT_W'(GRID_SIZE)))
			r = EXT_W'(GRID_SIZE);
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== src/life_automaton_grid.sv =====
// top level: life grid with cell access and generation sequencer
// set, clear or read: the row is read on acceptance; the cell state writes the changed row
// and loads the result once the output slot is free. advance: after a prime state, one row
// per cycle of clamped height h is read, updated, written; then done, at once if h is 0
// one item is in work at a time; a new item is accepted while a result waits on the output
// 64 x 64 bit ram, per-row valid bits make rows read dead after reset; async active-low reset
`default_nettype none

module life_automaton_grid import lifeg_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration write port
	input  wire logic        cfg_wr_en,
	input  wire logic        cfg_addr,
	input  wire logic [6:0]  cfg_wdata,
	// input stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,   // [1:0] opcode, [7:2] cell_x, [13:8] cell_y, [15:14] zero
	// output stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata    // [0] cell_alive, [1] out_of_area, [7:2] zero
);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_CELL  = 5'b00010,
		ST_PRIME = 5'b00100,
		ST_ROW   = 5'b01000,
		ST_DONE  = 5'b10000
	} state_t;

	state_t state_q;

	logic [EXT_W-1:0] width_q;
	logic [EXT_W-1:0] height_q;
	logic [EXT_W-1:0] w_eff;
	logic [EXT_W-1:0] h_eff;

	logic [1:0]       op_q;
	logic [5:0]       x_q;
	logic [5:0]       ycell_q;
	logic             oob_q;
	logic [EXT_W-1:0] y_q;

	logic [ROW_W-1:0] above_q;
	logic [ROW_W-1:0] cur_q;

	logic [GRID_SIZE-1:0] row_vld_q;
	logic                 rd_vld_q;

	logic              ram_wr_en;
	logic [ROW_AW-1:0] ram_wr_addr;
	logic [ROW_W-1:0]  ram_wr_data;
	logic              ram_rd_en;
	logic [ROW_AW-1:0] ram_rd_addr;
	logic [ROW_W-1:0]  ram_rd_data;
	logic [ROW_W-1:0]  rd_row;

	logic [1:0]       in_op;
	logic [5:0]       in_x;
	logic [5:0]       in_y;
	logic             in_acc;
	logic             in_oob;

	logic             out_valid_q;
	logic             out_alive_q;
	logic             out_oob_q;
	logic             slot_free;
	logic             out_load;
	logic             res_alive;

	logic [EXT_W:0]   y_next;
	logic             has_below;
	logic             last_row;
	logic [EXT_W-1:0] y_plus2;
	logic [ROW_W-1:0] below_row;
	logic [ROW_W-1:0] next_row;
	logic [ROW_W-1:0] cell_mod;
	logic             cell_bit;

	// input fields
	assign in_op  = s_tdata[1:0];
	assign in_x   = s_tdata[7:2];
	assign in_y   = s_tdata[13:8];
	assign s_tready = (state_q == ST_IDLE);
	assign in_acc = s_tvalid && s_tready;

	assign w_eff  = eff_extent(width_q);
	assign h_eff  = eff_extent(height_q);
	assign in_oob = ({1'b0, in_x} >= w_eff) || ({1'b0, in_y} >= h_eff);

	// output register
	assign slot_free = !out_valid_q || m_tready;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = {6'd0, out_oob_q, out_alive_q};

	// rows not yet written since reset read as dead
	assign rd_row = rd_vld_q ? ram_rd_data : '0;

	// row sequencing during an advance
	assign y_next    = {1'b0, y_q} + (EXT_W+1)'(1);
	assign has_below = (y_next < {1'b0, h_eff});
	assign last_row  = (y_next == {1'b0, h_eff});
	assign y_plus2   = y_q + EXT_W'(2);
	assign below_row = has_below ? rd_row : '0;

	lifeg_row_eval u_row_eval (
		.above_row (above_q),
		.cur_row   (cur_q),
		.below_row (below_row),
		.col_count (w_eff),
		.next_row  (next_row)
	);

	// single-cell read-modify-write
	assign cell_bit = rd_row[x_q[ROW_AW-1:0]];

	always_comb begin
		cell_mod  = rd_row;
		res_alive = cell_bit;
		case (op_q)
			OP_SET: begin
				cell_mod[x_q[ROW_AW-1:0]] = 1'b1;
				res_alive = 1'b1;
			end
			OP_CLEAR: begin
				cell_mod[x_q[ROW_AW-1:0]] = 1'b0;
				res_alive = 1'b0;
			end
			default: begin
				res_alive = cell_bit;
			end
		endcase
		if (oob_q)
			res_alive = 1'b0;
	end

	// ram port control
	always_comb begin
		ram_wr_en   = 1'b0;
		ram_wr_addr = y_q[ROW_AW-1:0];
		ram_wr_data = next_row;
		ram_rd_en   = 1'b0;
		ram_rd_addr = in_y[ROW_AW-1:0];
		out_load    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				ram_rd_en = in_acc;
				if (in_op == OP_ADVANCE)
					ram_rd_addr = '0;
			end
			ST_CELL: begin
				out_load    = slot_free;
				ram_wr_en   = slot_free && !oob_q
				           && ((op_q == OP_SET) || (op_q == OP_CLEAR));
				ram_wr_addr = ycell_q[ROW_AW-1:0];
				ram_wr_data = cell_mod;
			end
			ST_PRIME: begin
				ram_rd_en   = 1'b1;
				ram_rd_addr = ROW_AW'(1);
			end
			ST_ROW: begin
				ram_wr_en   = 1'b1;
				ram_rd_en   = 1'b1;
				ram_rd_addr = y_plus2[ROW_AW-1:0];
			end
			ST_DONE: begin
				out_load = slot_free;
			end
			default: begin
				ram_rd_en = 1'b0;
			end
		endcase
	end

	lifeg_ram #(
		.WIDTH (ROW_W),
		.DEPTH (GRID_SIZE)
	) u_grid_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= EXT_RESET;
			height_q <= EXT_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_addr)
				REG_ACTIVE_WIDTH:  width_q  <= cfg_wdata;
				REG_ACTIVE_HEIGHT: height_q <= cfg_wdata;
				default:           width_q  <= width_q;
			endcase
		end
	end

	// per-row valid bits and the valid tag of the read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
			rd_vld_q  <= 1'b0;
		end else begin
			if (ram_wr_en)
				row_vld_q[ram_wr_addr] <= 1'b1;
			if (ram_rd_en)
				rd_vld_q <= row_vld_q[ram_rd_addr];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			y_q     <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						y_q <= '0;
						if (in_op != OP_ADVANCE)
							state_q <= ST_CELL;
						else if (h_eff == '0)
							state_q <= ST_DONE;
						else
							state_q <= ST_PRIME;
					end
				end
				ST_CELL: begin
					if (slot_free)
						state_q <= ST_IDLE;
				end
				ST_PRIME: begin
					state_q <= ST_ROW;
				end
				ST_ROW: begin
					y_q <= y_next[EXT_W-1:0];
					if (last_row)
						state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (slot_free)
						state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// item fields and row window
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			above_q <= '0;
			cur_q   <= '0;
		end else begin
			if (state_q == ST_PRIME) begin
				above_q <= '0;
				cur_q   <= rd_row;
			end else if (state_q == ST_ROW) begin
				above_q <= cur_q;
				cur_q   <= rd_row;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_q    <= in_op;
			x_q     <= in_x;
			ycell_q <= in_y;
			oob_q   <= in_oob && (in_op != OP_ADVANCE);
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_alive_q <= 1'b0;
			out_oob_q   <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
				out_alive_q <= (state_q == ST_CELL) ? res_alive : 1'b0;
				out_oob_q   <= (state_q == ST_CELL) ? oob_q : 1'b0;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// ===== src/lifeg_ram.sv =====
// generic single-write, single-read synchronous ram with registered read
`default_nettype none

module lifeg_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wr_addr] <= wr_data;
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en)
			rd_data <= mem_q[rd_addr];
	end

endmodule

`default_nettype wire

// ===== src/lifeg_row_eval.sv =====
// one-row B3/S23 update from the previous-generation rows above, current and below
`default_nettype none

module lifeg_row_eval import lifeg_pkg::*; (
	input  wire logic [ROW_W-1:0] above_row,
	input  wire logic [ROW_W-1:0] cur_row,
	input  wire logic [ROW_W-1:0] below_row,
	input  wire logic [EXT_W-1:0] col_count,
	output logic      [ROW_W-1:0] next_row
);

	logic [ROW_W-1:0] col_mask;
	logic [ROW_W+1:0] a_pad;
	logic [ROW_W+1:0] c_pad;
	logic [ROW_W+1:0] b_pad;

	// columns inside the active area
	always_comb begin
		for (int i = 0; i < ROW_W; i++)
			col_mask[i] = (i < int'(col_count));
	end

	// cells outside the area count as dead, plus a dead border on each side
	assign a_pad = {1'b0, above_row & col_mask, 1'b0};
	assign c_pad = {1'b0, cur_row & col_mask, 1'b0};
	assign b_pad = {1'b0, below_row & col_mask, 1'b0};

	// neighbor count and rule per column; columns beyond the area keep their value
	always_comb begin
		logic [3:0] cnt;
		logic       nx;
		for (int x = 0; x < ROW_W; x++) begin
			cnt = 4'(a_pad[x]) + 4'(a_pad[x+1]) + 4'(a_pad[x+2])
			    + 4'(c_pad[x]) + 4'(c_pad[x+2])
			    + 4'(b_pad[x]) + 4'(b_pad[x+1]) + 4'(b_pad[x+2]);
			nx = (cnt == 4'd3) || (cur_row[x] && (cnt == 4'd2));
			next_row[x] = col_mask[x] ? nx : cur_row[x];
		end
	end

endmodule

`default_nettype wire

// ===== src/lifeg_checker.sv =====
// port-level checker for the life grid, bound to the top level
`default_nettype none

`include "assert_macros.svh"

module lifeg_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [7:0]  m_tdata
);

	logic [1:0] pend_q;
	logic       s_acc;
	logic       m_acc;

	assign s_acc = s_tvalid && s_tready;
	assign m_acc = m_tvalid && m_tready;

	// transactions accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pend_q <= '0;
		else if (s_acc && !m_acc)
			pend_q <= pend_q + 2'd1;
		else if (m_acc && !s_acc)
			pend_q <= pend_q - 2'd1;
	end

	`LG_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata),
		"result changed while stalled")
	`LG_ASSERT(a_oob_dead, m_tvalid && m_tdata[1] |-> !m_tdata[0],
		"out-of-area result reports a live cell")
	`LG_ASSERT(a_no_invent, m_tvalid |-> pend_q != 2'd0,
		"result without an accepted transaction")
	`LG_ASSERT(a_pend_bound, pend_q != 2'd3,
		"more than two transactions outstanding")

endmodule

bind life_automaton_grid lifeg_checker u_lifeg_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire
